>>> src/tpb_pkg.sv
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared types and constants for the tinted pixel blit engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpb_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned POS_W   = $clog2(MAX_DIM);   // column / row counters
  localparam int unsigned DIM_W   = POS_W + 1;         // holds MAX_DIM itself
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [8:0] LEVEL_FULL   = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_X        = 4'd0,
    REG_DEST_Y        = 4'd1,
    REG_PITCH_BYTES   = 4'd2,
    REG_IMAGE_WIDTH   = 4'd3,
    REG_IMAGE_HEIGHT  = 4'd4,
    REG_BLEND_LEVEL   = 4'd5,
    REG_TINT_COLOR    = 4'd6,
    REG_COPY_LAST_ROW = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
  } pix_in_t;

  typedef struct packed {
    logic [31:0] fb_address;
    logic [31:0] pixel_word;
    logic        frame_end;
  } pix_out_t;

endpackage

`default_nettype wire

>>> src/tpb_blend.sv
// ----------------------------------------------------------------------------
// tpb_blend
// One color component moved toward the tint: c + (t-c)*level/256, with the
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpb_blend (
  input  logic [7:0] comp_i,
  input  logic [7:0] tint_i,
  input  logic [8:0] level_i,
  output logic [7:0] comp_o
);

  logic [8:0]  diff;
  logic        diff_neg;
  logic [7:0]  diff_mag;
  logic [16:0] prod;
  logic [7:0]  step;

  always_comb begin
    diff     = {1'b0, tint_i} - {1'b0, comp_i};
    diff_neg = diff[8];
    diff_mag = diff_neg ? 8'(-diff) : diff[7:0];
    // magnitude path gives truncation toward zero for both signs
    prod     = 17'(diff_mag) * 17'(level_i);
    step     = prod[15:8];  // |t-c|*level/256 never exceeds 255 while level is at most 256
    comp_o   = diff_neg ? (comp_i - step) : (comp_i + step);
  end

endmodule

`default_nettype wire

>>> src/tinted_pixel_blit_engine.sv
// Path: an input beat is held in the input register, then in the result register,
// which drives the output beat.
// Throughput: one pixel per cycle, sustained while the output side takes beats.
// The critical path is the row-times-pitch multiply in the second stage.
// Reset: config registers return to their defaults, position counters to zero,
// both pipeline stages empty.
// ----------------------------------------------------------------------------
// tinted_pixel_blit_engine
// Raster position tracking, framebuffer address generation and tint blending
// of RGB888 source pixels into ARGB8888 framebuffer writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tinted_pixel_blit_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tpb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tpb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tpb_pkg::pix_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tpb_pkg::pix_out_t                 out_data_o
);

  import tpb_pkg::*;

  // configuration
  logic [11:0]      dest_x_q;
  logic [11:0]      dest_y_q;
  logic [15:0]      pitch_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic [8:0]       level_q;
  logic [23:0]      tint_q;
  logic [11:0]      copy_row_q;

  // position
  logic [POS_W-1:0] col_q, row_q;

  // stage 1
  logic             s1_valid_q;
  pix_in_t          s1_pix_q;
  logic [POS_W-1:0] s1_col_q, s1_row_q;
  logic             s1_blend_q;
  logic             s1_last_q;

  // result
  logic             out_valid_q;
  pix_out_t         out_data_q;

  logic             in_fire;
  logic             s1_ready;
  logic             out_free;
  logic [DIM_W-1:0] width_eff, height_eff;
  logic [8:0]       level_eff;
  logic             row_end, last;

  logic [DIM_W-1:0] ypos, xpos;
  logic [28:0]      row_off;
  logic [31:0]      addr;
  logic [7:0]       red_bl, green_bl, blue_bl;
  logic [7:0]       red_o, green_o, blue_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q   <= '0;
      dest_y_q   <= '0;
      pitch_q    <= '0;
      width_q    <= DIM_W'(1);
      height_q   <= DIM_W'(1);
      level_q    <= LEVEL_FULL;
      tint_q     <= 24'h7F4E32;
      copy_row_q <= 12'd120;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEST_X:        dest_x_q   <= cfg_data_i[11:0];
        REG_DEST_Y:        dest_y_q   <= cfg_data_i[11:0];
        REG_PITCH_BYTES:   pitch_q    <= cfg_data_i[15:0];
        REG_IMAGE_WIDTH:   width_q    <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  height_q   <= cfg_data_i[DIM_W-1:0];
        REG_BLEND_LEVEL:   level_q    <= cfg_data_i[8:0];
        REG_TINT_COLOR:    tint_q     <= cfg_data_i[23:0];
        REG_COPY_LAST_ROW: copy_row_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // handshake chain
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || out_free;
  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i && s1_ready;

  // clamped dimensions and level
  always_comb begin
    if (width_q == '0)                      width_eff = DIM_W'(1);
    else if (width_q > DIM_W'(MAX_DIM))     width_eff = DIM_W'(MAX_DIM);
    else                                    width_eff = width_q;
    if (height_q == '0)                     height_eff = DIM_W'(1);
    else if (height_q > DIM_W'(MAX_DIM))    height_eff = DIM_W'(MAX_DIM);
    else                                    height_eff = height_q;
    level_eff = (level_q > LEVEL_FULL) ? LEVEL_FULL : level_q;
    // a position left past a shrunk image also ends the row / frame
    row_end   = ({1'b0, col_q} + DIM_W'(1)) >= width_eff;
    last      = row_end && (({1'b0, row_q} + DIM_W'(1)) >= height_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (last) begin
        col_q <= '0;
        row_q <= '0;
      end else if (row_end) begin
        col_q <= '0;
        row_q <= row_q + POS_W'(1);
      end else begin
        col_q <= col_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q   <= in_data_i;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_blend_q <= row_q > copy_row_q;
      s1_last_q  <= last;
    end
  end

  // stage 2: address and blend
  tpb_blend u_blend_r (
    .comp_i  (s1_pix_q.src_red),
    .tint_i  (tint_q[23:16]),
    .level_i (level_eff),
    .comp_o  (red_bl)
  );

  tpb_blend u_blend_g (
    .comp_i  (s1_pix_q.src_green),
    .tint_i  (tint_q[15:8]),
    .level_i (level_eff),
    .comp_o  (green_bl)
  );

  tpb_blend u_blend_b (
    .comp_i  (s1_pix_q.src_blue),
    .tint_i  (tint_q[7:0]),
    .level_i (level_eff),
    .comp_o  (blue_bl)
  );

  always_comb begin
    ypos    = DIM_W'(dest_y_q) + DIM_W'(s1_row_q);
    xpos    = DIM_W'(dest_x_q) + DIM_W'(s1_col_q);
    row_off = 29'(ypos) * 29'(pitch_q);
    addr    = 32'(row_off) + {17'd0, xpos, 2'b00};
    red_o   = s1_blend_q ? red_bl   : s1_pix_q.src_red;
    green_o = s1_blend_q ? green_bl : s1_pix_q.src_green;
    blue_o  = s1_blend_q ? blue_bl  : s1_pix_q.src_blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_data_q.fb_address <= addr;
      out_data_q.pixel_word <= {ALPHA_OPAQUE, red_o, green_o, blue_o};
      out_data_q.frame_end  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> verif/tpb_blit_checker.sv
// ----------------------------------------------------------------------------
// tpb_blit_checker
// Watches the config, pixel and framebuffer-write channels of the tinted pixel
// blit engine. Keeps its own copy of the registers and the raster position,
// predicts one framebuffer write per accepted pixel and compares every output
// beat against the oldest predicted write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpb_blit_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [tpb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tpb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  tpb_pkg::pix_in_t               in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  tpb_pkg::pix_out_t              out_data_i,
  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);

  import tpb_pkg::*;

  localparam int unsigned BYTES_PER_PIXEL = 4;

  logic [11:0] dest_x_q;
  logic [11:0] dest_y_q;
  logic [15:0] pitch_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [8:0]  level_q;
  logic [23:0] tint_q;
  logic [11:0] copy_row_q;
  int unsigned col_q;
  int unsigned row_q;
  int unsigned errors;
  pix_out_t    fb_writes_q[$];

  function automatic int unsigned dim_clamp(input logic [12:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // c + (t - c) * level / 256, division truncating toward zero
  function automatic logic [7:0] tint_blend(input logic [7:0] c, input logic [7:0] t,
                                            input int level);
    int delta;
    delta = (int'(t) - int'(c)) * level;
    return 8'(int'(c) + delta / 256);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pix_out_t    want;
    int unsigned w;
    int unsigned h;
    int          lvl;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [63:0] addr;
    logic        row_done;
    logic        frame_done;
    if (!rst_ni) begin
      dest_x_q     = '0;
      dest_y_q     = '0;
      pitch_q      = '0;
      width_q      = 13'd1;
      height_q     = 13'd1;
      level_q      = LEVEL_FULL;
      tint_q       = 24'h7F4E32;
      copy_row_q   = 12'd120;
      col_q        = 0;
      row_q        = 0;
      errors       = 0;
      fb_writes_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (fb_writes_q.size() == 0) begin
          $error("unexpected write beat: fb_address %h pixel_word %h frame_end %b",
                 out_data_i.fb_address, out_data_i.pixel_word, out_data_i.frame_end);
          errors++;
        end else begin
          want = fb_writes_q.pop_front();
          if (out_data_i.fb_address !== want.fb_address) begin
            $error("fb_address: expected %h, actual %h", want.fb_address,
                   out_data_i.fb_address);
            errors++;
          end
          if (out_data_i.pixel_word !== want.pixel_word) begin
            $error("pixel_word: expected %h, actual %h", want.pixel_word,
                   out_data_i.pixel_word);
            errors++;
          end
          if (out_data_i.frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, actual %b", want.frame_end,
                   out_data_i.frame_end);
            errors++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        w   = dim_clamp(width_q);
        h   = dim_clamp(height_q);
        lvl = (level_q > LEVEL_FULL) ? int'(LEVEL_FULL) : int'(level_q);
        r   = in_data_i.src_red;
        g   = in_data_i.src_green;
        b   = in_data_i.src_blue;
        addr = (64'(dest_y_q) + row_q) * pitch_q
             + (64'(dest_x_q) + col_q) * BYTES_PER_PIXEL;
        if (row_q > copy_row_q) begin
          r = tint_blend(r, tint_q[23:16], lvl);
          g = tint_blend(g, tint_q[15:8], lvl);
          b = tint_blend(b, tint_q[7:0], lvl);
        end
        // a position left beyond a shrunken image ends the row / frame at once
        row_done   = (col_q + 1 >= w);
        frame_done = row_done && (row_q + 1 >= h);
        want.fb_address = addr[31:0];
        want.pixel_word = {ALPHA_OPAQUE, r, g, b};
        want.frame_end  = frame_done;
        fb_writes_q = {fb_writes_q, want};
        if (frame_done) begin
          col_q = 0;
          row_q = 0;
        end else if (row_done) begin
          col_q = 0;
          row_q++;
        end else begin
          col_q++;
        end
      end

      if (cfg_valid_i && cfg_ready_i && cfg_index_i <= REG_COPY_LAST_ROW) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DEST_X:        dest_x_q   = cfg_data_i[11:0];
          REG_DEST_Y:        dest_y_q   = cfg_data_i[11:0];
          REG_PITCH_BYTES:   pitch_q    = cfg_data_i[15:0];
          REG_IMAGE_WIDTH:   width_q    = cfg_data_i[12:0];
          REG_IMAGE_HEIGHT:  height_q   = cfg_data_i[12:0];
          REG_BLEND_LEVEL:   level_q    = cfg_data_i[8:0];
          REG_TINT_COLOR:    tint_q     = cfg_data_i[23:0];
          REG_COPY_LAST_ROW: copy_row_q = cfg_data_i[11:0];
          default: ;
        endcase
      end

      pending_o    <= fb_writes_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

>>> verif/tb_tinted_pixel_blit_engine.sv
// ----------------------------------------------------------------------------
// tb_tinted_pixel_blit_engine
// Drives directed and random pixel streams and register settings into the
// blit engine under four idle/stall mixes, with a long output hold-off, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tinted_pixel_blit_engine;
  import tpb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned BEATS_PER_SET = 60;
  localparam int unsigned SETS_PER_MODE = 7;
  localparam int unsigned CFG_IDX_MAX   = 2**CFG_IDX_W - 1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  pix_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  pix_out_t              out_data_o;

  int unsigned pending_writes;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_request = 1'b0;

  tinted_pixel_blit_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  tpb_blit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .pending_o    (pending_writes),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL tinted_pixel_blit_engine");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic push_pixel(input pix_in_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // waits for every write to drain, then rewrites all registers
  task automatic program_blit(input logic [31:0] dx, input logic [31:0] dy,
                              input logic [31:0] pitch, input logic [31:0] w,
                              input logic [31:0] h, input logic [31:0] lvl,
                              input logic [31:0] tint, input logic [31:0] copy_row);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_writes != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_DEST_X, dx);
    write_reg(REG_DEST_Y, dy);
    write_reg(REG_PITCH_BYTES, pitch);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BLEND_LEVEL, lvl);
    write_reg(REG_TINT_COLOR, tint);
    write_reg(REG_COPY_LAST_ROW, copy_row);
    // unmapped index, must be dropped
    write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_MAX, REG_COPY_LAST_ROW + 1)), $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  // stray upper bits that the register width must discard
  function automatic logic [31:0] with_junk(input logic [31:0] v);
    if ($urandom_range(3) == 0) return v | {8'($urandom()), 24'h0};
    return v;
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t px;
    px = pix_in_t'(24'($urandom()));
    if ($urandom_range(3) == 0) begin
      px.src_red   = $urandom_range(1) ? 8'hFF : 8'h00;
      px.src_green = $urandom_range(1) ? 8'hFF : 8'h00;
      px.src_blue  = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  initial begin
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] lvl;
    logic [31:0] copy_row;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: 1x1 image, every pixel ends a frame
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);

    // all-ones writes, zero width, oversized height and level, full tint
    program_blit(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0,
                 32'd8191, 32'd511, 32'hFFFFFF, 32'd0);
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h123456);
    push_pixel(24'h00FF00);

    // row left past the new height ends the frame; level zero keeps the pixel
    program_blit(32'd0, 32'd0, 32'd0, 32'd3, 32'd2, 32'd0, 32'd0, 32'd0);
    repeat (6) push_pixel(24'hA5C3E1);

    // half blend toward the reset tint, components above and below it
    program_blit(32'd1, 32'd2, 32'd64, 32'd8, 32'd3, 32'd128, 32'h7F4E32, 32'd0);
    push_pixel(24'hFF00FF);
    push_pixel(24'h00FF00);
    push_pixel(24'h808080);
    push_pixel(24'h7F4E32);
    push_pixel(24'h01FE33);

    // column left past the new width ends the row
    program_blit(32'd4095, 32'd0, 32'd16, 32'd2, 32'd2, 32'd257, 32'h00FF7F, 32'd0);
    repeat (4) push_pixel(24'h3C96F0);

    // oversized width
    program_blit(32'd7, 32'd9, 32'd1024, 32'd8191, 32'd1, 32'd255, 32'h7F4E32, 32'd0);
    push_pixel(24'hFF7F00);
    push_pixel(24'h0080FF);

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
        default: begin src_idle_pct = 31; sink_stall_pct = 31; end
      endcase
      for (int set = 0; set < SETS_PER_MODE; set++) begin
        case ($urandom_range(9))
          0:       w = 0;
          1:       w = $urandom_range(8191, MAX_DIM);
          default: w = $urandom_range(12, 1);
        endcase
        case ($urandom_range(9))
          0:       h = 0;
          1:       h = $urandom_range(8191, MAX_DIM);
          default: h = $urandom_range(8, 1);
        endcase
        case ($urandom_range(5))
          0:       lvl = 0;
          1:       lvl = LEVEL_FULL;
          2:       lvl = $urandom_range(511, LEVEL_FULL + 1);
          default: lvl = $urandom_range(LEVEL_FULL - 1, 1);
        endcase
        copy_row = ($urandom_range(7) == 0) ? 32'd4095 : $urandom_range(5);
        program_blit(with_junk($urandom_range(4095)), with_junk($urandom_range(4095)),
                     with_junk($urandom_range(65535)), with_junk(w), with_junk(h),
                     with_junk(lvl), with_junk($urandom_range(24'hFFFFFF)),
                     with_junk(copy_row));
        // back-pressure while the sender keeps offering beats
        if (mode == 0 && set == 3) hold_request = 1'b1;
        repeat (BEATS_PER_SET) push_pixel(rand_pixel());
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_writes != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS tinted_pixel_blit_engine");
    end else begin
      $display("FAIL tinted_pixel_blit_engine");
    end
    $finish;
  end

endmodule
